// ----- design/pah_pkg.sv -----
`timescale 1ns / 1ps

package pah_pkg;

  // Geometry of the projection set
  localparam int VEC_LEN     = 128;
  localparam int MAX_CENTRES = 256;

  localparam int COMP_W     = $clog2(VEC_LEN);
  localparam int IDX_W      = $clog2(MAX_CENTRES);
  localparam int CENTRES_W  = IDX_W + 1;
  localparam int COEF_DEPTH = MAX_CENTRES * VEC_LEN;
  localparam int COEF_AW    = IDX_W + COMP_W;

  // Arithmetic widths
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 48;
  localparam int COUNT_W = 32;

  localparam logic [CENTRES_W-1:0] CENTRES_RESET = CENTRES_W'(MAX_CENTRES);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DESC  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic KIND_CLASS = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    op_t                     operation;
    logic [IDX_W-1:0]        centre;
    logic [COMP_W-1:0]       component;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } out_t;

  // Writes into the projection engine memories
  typedef struct packed {
    logic                    coef_we;
    logic                    desc_we;
    logic [IDX_W-1:0]        centre;
    logic [COMP_W-1:0]       component;
    logic signed [VAL_W-1:0] value;
  } pah_wr_t;

  typedef struct packed {
    logic                 start;
    logic [CENTRES_W-1:0] n_eff;
  } pah_ctl_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best_idx;
  } pah_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PROJ    = 2'd1,
    ST_CNT_RD  = 2'd2,
    ST_CNT_UPD = 2'd3
  } state_t;

endpackage

// ----- design/pah_proj.sv -----
`timescale 1ns / 1ps

module pah_proj import pah_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pah_wr_t  wr,
  input  pah_ctl_t ctl,
  output pah_sts_t sts
);

  // Memories: coefficients by {vector, component}, descriptor by component
  logic signed [VAL_W-1:0] cmem [COEF_DEPTH];
  logic signed [VAL_W-1:0] dmem [VEC_LEN];

  logic signed [VAL_W-1:0]  coef_rd;
  logic signed [VAL_W-1:0]  desc_rd;
  logic signed [PROD_W-1:0] prod;

  // Sequencer
  logic              active;
  logic              issuing;
  logic [IDX_W-1:0]  vec_i;
  logic [COMP_W-1:0] comp_j;
  logic [IDX_W-1:0]  n_last;

  // Pipeline tags: stage 1 = read data, stage 2 = product
  logic             s1_valid, s1_first, s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic             s2_valid, s2_first, s2_last;
  logic [IDX_W-1:0] s2_idx;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] best;
  logic [IDX_W-1:0]        best_idx;

  logic issue_last;
  logic done;

  assign issue_last = (comp_j == COMP_W'(VEC_LEN - 1)) && (vec_i == n_last);
  assign done       = active && !issuing && !s1_valid && !s2_valid;

  assign acc_sum = (s2_first ? '0 : acc)
                 + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Memory writes, reads and the multiplier stage
  always_ff @(posedge clk) begin
    if (wr.coef_we) begin
      cmem[{wr.centre, wr.component}] <= wr.value;
    end
    if (wr.desc_we) begin
      dmem[wr.component] <= wr.value;
    end
    coef_rd <= cmem[{vec_i, comp_j}];
    desc_rd <= dmem[comp_j];
    prod    <= coef_rd * desc_rd;
  end

  // Sequencer, pipeline tags, accumulate and argmax
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      issuing  <= 1'b0;
      vec_i    <= '0;
      comp_j   <= '0;
      n_last   <= '0;
      s1_valid <= 1'b0;
      s1_first <= 1'b0;
      s1_last  <= 1'b0;
      s1_idx   <= '0;
      s2_valid <= 1'b0;
      s2_first <= 1'b0;
      s2_last  <= 1'b0;
      s2_idx   <= '0;
      acc      <= '0;
      best     <= '0;
      best_idx <= '0;
    end else begin
      s1_valid <= issuing;
      s1_first <= (comp_j == '0);
      s1_last  <= (comp_j == COMP_W'(VEC_LEN - 1));
      s1_idx   <= vec_i;
      s2_valid <= s1_valid;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_idx   <= s1_idx;

      if (ctl.start) begin
        active   <= 1'b1;
        issuing  <= (ctl.n_eff != '0);
        vec_i    <= '0;
        comp_j   <= '0;
        n_last   <= IDX_W'(ctl.n_eff - CENTRES_W'(1));
        best     <= '0;
        best_idx <= '0;
      end else begin
        if (issuing) begin
          comp_j <= comp_j + COMP_W'(1);
          if (comp_j == COMP_W'(VEC_LEN - 1)) begin
            vec_i <= vec_i + IDX_W'(1);
          end
          if (issue_last) begin
            issuing <= 1'b0;
          end
        end
        if (s2_valid) begin
          acc <= acc_sum;
          if (s2_last && (acc_sum > best)) begin
            best     <= acc_sum;
            best_idx <= s2_idx;
          end
        end
        if (done) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign sts.done     = done;
  assign sts.best_idx = best_idx;

  // Product tags follow the read tags in the next cycle
  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("product stage valid without a read one cycle earlier");

  // A winner other than vector 0 always lies among the vectors compared
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && issuing == 1'b0 && best_idx != '0) |-> (best_idx <= n_last))
    else $error("winning vector beyond the vectors in use");

endmodule

// ----- design/projection_argmax_histogram.sv -----
`timescale 1ns / 1ps

// A coefficient load or a non-final descriptor component is taken with no result.
// A final component (index 127) yields its result once the single MAC has walked the
// coefficient memory over n vectors, n being the number of vectors in use.
// A bin read yields its result after the count read and update states; a clear gives none.
// One transaction is worked at a time; a finished result waits in the output register.
// Reset (rst, synchronous) zeroes all bin counts and sets 256 vectors in use.

module projection_argmax_histogram import pah_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CENTRES_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CENTRES_W-1:0] centres;
  logic [CENTRES_W-1:0] n_eff;

  // Bin counts with a valid bit per entry; an invalid entry reads as zero
  logic [COUNT_W-1:0]     bmem [MAX_CENTRES];
  logic [MAX_CENTRES-1:0] bvalid;
  logic [COUNT_W-1:0]     rdata;
  logic                   rvld;

  logic [IDX_W-1:0] sel_bin;
  logic             kind_q;

  logic               accept;
  logic               out_free;
  logic               upd_fire;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] new_count;

  pah_wr_t  wr;
  pah_ctl_t ctl;
  pah_sts_t sts;

  pah_proj u_proj (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .ctl (ctl),
    .sts (sts)
  );

  assign n_eff = (centres > CENTRES_W'(MAX_CENTRES)) ? CENTRES_W'(MAX_CENTRES) : centres;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      centres <= CENTRES_RESET;
    end else if (cfg_we) begin
      centres <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_READ) begin
            state_next = ST_CNT_RD;
          end else if (in_data.operation == OP_DESC &&
                       in_data.component == COMP_W'(VEC_LEN - 1)) begin
            state_next = ST_PROJ;
          end
        end
      end
      ST_PROJ: begin
        if (sts.done) begin
          state_next = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        state_next = ST_CNT_UPD;
      end
      ST_CNT_UPD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_stall     = (state != ST_IDLE);
    accept       = in_valid && (state == ST_IDLE);
    wr.coef_we   = accept && (in_data.operation == OP_LOAD);
    wr.desc_we   = accept && (in_data.operation == OP_DESC);
    wr.centre    = in_data.centre;
    wr.component = in_data.component;
    wr.value     = in_data.value;
    ctl.start    = wr.desc_we && (in_data.component == COMP_W'(VEC_LEN - 1));
    ctl.n_eff    = n_eff;
    upd_fire     = (state == ST_CNT_UPD) && out_free;
  end

  assign out_free  = !out_valid || !out_stall;
  assign cur_count = rvld ? rdata : '0;
  assign new_count = (kind_q == KIND_READ)  ? cur_count :
                     (cur_count == '1)      ? cur_count :
                                              cur_count + COUNT_W'(1);

  // State and transaction context
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sel_bin <= '0;
      kind_q  <= KIND_CLASS;
    end else begin
      state <= state_next;
      if (accept && in_data.operation == OP_READ) begin
        sel_bin <= in_data.centre;
        kind_q  <= KIND_READ;
      end else if (state == ST_PROJ && sts.done) begin
        sel_bin <= sts.best_idx;
        kind_q  <= KIND_CLASS;
      end
    end
  end

  // Count memory: read in CNT_RD, write back on a classification update
  always_ff @(posedge clk) begin
    if (state == ST_CNT_RD) begin
      rdata <= bmem[sel_bin];
    end
    if (upd_fire && kind_q == KIND_CLASS) begin
      bmem[sel_bin] <= new_count;
    end
  end

  // Valid bits; a clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
      rvld   <= 1'b0;
    end else begin
      if (state == ST_CNT_RD) begin
        rvld <= bvalid[sel_bin];
      end
      if (accept && in_data.operation == OP_CLEAR) begin
        bvalid <= '0;
      end else if (upd_fire && kind_q == KIND_CLASS) begin
        bvalid[sel_bin] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_data.kind  <= kind_q;
      out_data.bin   <= sel_bin;
      out_data.count <= new_count;
    end
  end

  // The engine reports completion only while the controller waits for it
  a_done_in_proj: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == ST_PROJ))
    else $error("projection done outside the projection phase");

  // A classification result always carries a count of at least one
  a_class_nonzero: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && kind_q == KIND_CLASS) |-> (new_count != '0))
    else $error("classification produced a zero count");

  // The update step is reached only through a count read
  a_upd_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNT_UPD) |-> ($past(state) == ST_CNT_RD || $past(state) == ST_CNT_UPD))
    else $error("count update without a preceding read");

endmodule

// ----- test/histogram_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the config port, keeps its own copy of the
// projection store, descriptor and bin counts, and checks every result
// transaction against the oldest awaited one.
module histogram_checker import pah_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CENTRES_W-1:0] cfg_data,
  output int                   err_count,
  output int                   pend_cnt
);

  logic signed [VAL_W-1:0] coef_mem [MAX_CENTRES][VEC_LEN];
  logic signed [VAL_W-1:0] desc_buf [VEC_LEN];
  logic [COUNT_W-1:0]      bin_cnt  [MAX_CENTRES];
  logic [CENTRES_W-1:0]    centres_cfg;
  out_t                    awaited_q [$];
  int                      result_num;

  task automatic report_mismatch(input string msg);
    $display("%0t ns, result %0d: %s", $time, result_num, msg);
    err_count++;
  endtask

  // Index of the vector with the largest dot product, the first one on a tie;
  // the best starts at zero, so nothing positive means bin 0
  function automatic logic [IDX_W-1:0] best_projection(input int n);
    logic signed [ACC_W-1:0] best;
    logic signed [ACC_W-1:0] acc;
    logic [IDX_W-1:0]        idx;
    best = '0;
    idx  = '0;
    for (int v = 0; v < n; v++) begin
      acc = '0;
      for (int j = 0; j < VEC_LEN; j++)
        acc = acc + coef_mem[v][j] * desc_buf[j];
      if (acc > best) begin
        best = acc;
        idx  = IDX_W'(v);
      end
    end
    return idx;
  endfunction

  always @(posedge clk) begin
    in_t                  item;
    out_t                 fresh;
    out_t                 oldest;
    logic [CENTRES_W-1:0] n_use;
    if (rst) begin
      foreach (bin_cnt[b]) bin_cnt[b] = '0;
      centres_cfg = CENTRES_RESET;
      awaited_q.delete();
      err_count  = 0;
      result_num = 0;
    end else begin
      if (cfg_we)
        centres_cfg = cfg_data;

      // result side first: a result always trails the transaction behind it
      if (out_valid && !out_stall) begin
        result_num++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: kind %0d bin %0d count %0d",
                                    out_data.kind, out_data.bin, out_data.count));
        end else begin
          oldest = awaited_q.pop_front();
          if (out_data.kind !== oldest.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, oldest.kind));
          if (out_data.bin !== oldest.bin)
            report_mismatch($sformatf("bin %0d, expected %0d", out_data.bin, oldest.bin));
          if (out_data.count !== oldest.count)
            report_mismatch($sformatf("count %0d, expected %0d", out_data.count, oldest.count));
        end
      end

      // input side: update the state copy and queue what this transaction yields
      if (in_valid && !in_stall) begin
        item = in_data;
        case (item.operation)
          OP_LOAD: begin
            coef_mem[item.centre][item.component] = item.value;
          end
          OP_DESC: begin
            desc_buf[item.component] = item.value;
            if (item.component == COMP_W'(VEC_LEN - 1)) begin
              n_use = (centres_cfg > MAX_CENTRES) ? CENTRES_W'(MAX_CENTRES) : centres_cfg;
              fresh.kind = KIND_CLASS;
              fresh.bin  = best_projection(n_use);
              if (bin_cnt[fresh.bin] != '1)
                bin_cnt[fresh.bin]++;
              fresh.count = bin_cnt[fresh.bin];
              awaited_q.push_back(fresh);
            end
          end
          OP_READ: begin
            fresh.kind  = KIND_READ;
            fresh.bin   = item.centre;
            fresh.count = bin_cnt[item.centre];
            awaited_q.push_back(fresh);
          end
          OP_CLEAR: begin
            foreach (bin_cnt[b]) bin_cnt[b] = '0;
          end
        endcase
      end
    end
    pend_cnt <= awaited_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pah_pkg::*;

  localparam int RUN_LIMIT    = 4_000_000;
  localparam int SETTLE       = 12;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES       = 10;
  localparam int FILLED       = 6;    // vectors whose coefficients are all loaded

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CENTRES_W-1:0] cfg_data  = '0;

  int err_count;
  int pend_cnt;
  int idle_pct = 0;   // percent chance that an idle burst starts
  int stall_left;
  int cyc;

  projection_argmax_histogram DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  histogram_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pend_cnt  (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls in bursts that start at random
  always @(posedge clk) begin
    if (stall_left == 0 && $urandom_range(99) < idle_pct)
      stall_left = $urandom_range(10, 1);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    cyc = 0;
    while (cyc < RUN_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_t pack_item(input op_t op, input int centre, input int comp,
                                    input int value);
    in_t item;
    item.operation = op;
    item.centre    = IDX_W'(centre);
    item.component = COMP_W'(comp);
    item.value     = VAL_W'(value);
    return item;
  endfunction

  // Signed 16-bit value, leaning on the extremes
  function automatic int pick_value();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Mostly a vector in use, sometimes any bin
  function automatic int pick_centre(input int n);
    return ($urandom_range(3) != 0) ? int'($urandom_range(n - 1)) : int'($urandom_range(255));
  endfunction

  // One input transaction, after an optional idle burst
  task automatic push_transaction(input in_t item);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(10, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every awaited result is in and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_centres(input int n);
    drain();
    cfg_data <= CENTRES_W'(n);
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int n_phase;
    int sent;
    int r;
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 25;

    // counts start at zero; both ends of the bin range
    push_transaction(pack_item(OP_READ, 0, 0, 0));
    push_transaction(pack_item(OP_READ, 255, 127, -1));

    // no vectors in use: filling the descriptor ends in a pick of bin 0
    set_centres(0);
    for (int j = 0; j < VEC_LEN; j++)
      push_transaction(pack_item(OP_DESC, $urandom_range(255), j, 0));
    push_transaction(pack_item(OP_READ, 0, 0, 0));
    push_transaction(pack_item(OP_CLEAR, $urandom_range(255), $urandom_range(127), 0));
    push_transaction(pack_item(OP_READ, 0, 0, 0));

    // fill the leading vectors; no vector count above FILLED is used afterwards
    idle_pct = 10;
    for (int c = 0; c < FILLED; c++)
      for (int j = 0; j < VEC_LEN; j++)
        push_transaction(pack_item(OP_LOAD, c, j, pick_value()));
    idle_pct = 25;

    // every filled vector in use: zero descriptor ties everywhere, then extremes
    set_centres(FILLED);
    push_transaction(pack_item(OP_DESC, $urandom_range(255), VEC_LEN - 1, 0));
    push_transaction(pack_item(OP_DESC, $urandom_range(255), VEC_LEN - 1, 32767));
    push_transaction(pack_item(OP_DESC, $urandom_range(255), VEC_LEN - 1, -32768));

    // two vectors with equal largest products: the first wins
    set_centres(2);
    for (int j = 119; j < VEC_LEN; j++) begin
      push_transaction(pack_item(OP_LOAD, 0, j, (j == 119) ? 0 : -32768));
      push_transaction(pack_item(OP_LOAD, 1, j, (j == 119) ? 0 : -32768));
    end
    for (int j = 119; j < VEC_LEN; j++)
      push_transaction(pack_item(OP_DESC, $urandom_range(255), j, -32768));
    // one more term lifts the second vector past the first
    push_transaction(pack_item(OP_LOAD, 1, 119, -32768));
    push_transaction(pack_item(OP_DESC, $urandom_range(255), VEC_LEN - 1, -32768));
    push_transaction(pack_item(OP_READ, 0, 0, 0));
    push_transaction(pack_item(OP_READ, 1, 0, 0));

    // random phases, each with its own vector count and idling level
    sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      n_phase  = (p == 6) ? FILLED : $urandom_range(FILLED, 1);
      idle_pct = (p == PHASES - 1 || p % 3 == 1) ? 0 : ((p % 3 == 0) ? 20 : 45);
      set_centres(n_phase);
      while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(99);
        if (r < 35) begin
          // a few components, then the last one to classify
          k = $urandom_range(6, 0);
          repeat (k)
            push_transaction(pack_item(OP_DESC, $urandom_range(255), $urandom_range(126),
                                       pick_value()));
          push_transaction(pack_item(OP_DESC, $urandom_range(255), VEC_LEN - 1,
                                     pick_value()));
          sent += k + 1;
        end else if (r < 58) begin
          k = $urandom_range(8, 1);
          repeat (k)
            push_transaction(pack_item(OP_LOAD, pick_centre(n_phase), $urandom_range(127),
                                       pick_value()));
          sent += k;
        end else if (r < 83) begin
          push_transaction(pack_item(OP_READ, pick_centre(n_phase), $urandom_range(127),
                                     pick_value()));
          sent++;
        end else if (r < 86) begin
          push_transaction(pack_item(OP_CLEAR, $urandom_range(255), $urandom_range(127),
                                     pick_value()));
          sent++;
        end else if (r < 88) begin
          drain();
        end else begin
          push_transaction(pack_item(OP_DESC, $urandom_range(255), $urandom_range(126),
                                     pick_value()));
          sent++;
        end
      end
    end

    drain();
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- projection_argmax_histogram.f -----
design/pah_pkg.sv
design/pah_proj.sv
design/projection_argmax_histogram.sv
test/histogram_checker.sv
test/tb_top.sv
